FILE: sv/skt_pkg.sv
// Package for the sorted key table: sizes, status and request codes,
// and the record and control structures shared by the cell and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package skt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int KEY_W    = 32;
  localparam int AGE_W    = 8;
  localparam int NAME_W   = 40;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [AGE_W-1:0]        age;
    logic [NAME_W-1:0]       name_head;
    logic [NAME_W-1:0]       name_tail;
  } rec_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
    rec_t req;
  } ctl_t;

endpackage

FILE: sv/skt_cell.sv
// One cell of the sorted record chain: holds a record, compares it with the
// broadcast request key and shifts records to or from its neighbours.
// Depends on skt_pkg.
`timescale 1ns / 1ps

module skt_cell
  import skt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  ctl_t ctl,
  input  logic valid,
  input  logic left_lt,
  input  rec_t left_rec,
  input  rec_t right_rec,
  output rec_t rec,
  output logic lt,
  output logic eq
);

  rec_t rec_r;
  rec_t rec_nxt;
  logic lt_r;
  logic eq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctl.cmp) begin
      lt_r <= valid && (rec_r.key < ctl.req.key);
      eq_r <= valid && (rec_r.key == ctl.req.key);
    end
  end

  // Cells at or beyond the insertion point move one place up; the first of
  // them takes the new record. On removal they all pull from the right.
  always_comb begin
    rec_nxt = rec_r;
    if (ctl.ins && !lt_r) begin
      rec_nxt = left_lt ? ctl.req : left_rec;
    end else if (ctl.rem && !lt_r) begin
      rec_nxt = right_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec = rec_r;
  assign lt  = lt_r;
  assign eq  = eq_r;

endmodule

FILE: sv/sorted_key_table.sv
// Sorted key table: each request passes a compare state, in which every cell
// registers its flags, then an apply state, in which the chain shifts and the
// result is registered; a new request is taken in the apply state, not while busy.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Synchronous active-low reset empties the table; stored records keep
// whatever they held and are never read until rewritten.
`timescale 1ns / 1ps

module sorted_key_table
  import skt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_kind,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [AGE_W-1:0]        in_age,
  input  logic [NAME_W-1:0]       in_name_first,
  input  logic [NAME_W-1:0]       in_name_rest,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [POS_W-1:0]        out_position,
  output logic [COUNT_W-1:0]      out_count,
  output logic [AGE_W-1:0]        out_found_age,
  output logic [NAME_W-1:0]       out_found_name_first,
  output logic [NAME_W-1:0]       out_found_name_rest
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  kind_t  kind_r;
  rec_t   req_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic                 out_valid_r;
  status_t              status_r, status_nxt;
  logic [POS_W-1:0]     position_r, position_nxt;
  rec_t                 found_r, found_nxt;

  ctl_t ctl;
  rec_t rec_vec [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] valid_vec;

  logic accept;
  logic any_eq;
  logic full;
  logic ins_ok;
  logic rem_ok;
  logic [IDX_W-1:0] hit_idx;
  rec_t hit_rec;

  assign busy   = (state_r == S_CMP);
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign any_eq = |eq_vec;
  assign ins_ok = (state_r == S_APPLY) && (kind_r == KIND_INSERT) && !any_eq && !full;
  assign rem_ok = (state_r == S_APPLY) && (kind_r == KIND_REMOVE) && any_eq;

  assign ctl.cmp = (state_r == S_CMP);
  assign ctl.ins = ins_ok;
  assign ctl.rem = rem_ok;
  assign ctl.req = req_r;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign valid_vec[g] = (CNT_W'(g) < count_r);
      skt_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .valid     (valid_vec[g]),
        .left_lt   ((g == 0) ? 1'b1 : lt_vec[(g == 0) ? 0 : g - 1]),
        .left_rec  (rec_vec[(g == 0) ? 0 : g - 1]),
        .right_rec (rec_vec[(g == CAPACITY - 1) ? g : g + 1]),
        .rec       (rec_vec[g]),
        .lt        (lt_vec[g]),
        .eq        (eq_vec[g])
      );
    end
  endgenerate

  // Keys are unique, so at most one equality flag is set and an OR over the
  // masked cells picks out the hit.
  always_comb begin
    hit_idx = '0;
    hit_rec = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (eq_vec[j]) begin
        hit_idx = hit_idx | IDX_W'(j);
        hit_rec = hit_rec | rec_vec[j];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  state_nxt = accept ? S_CMP : S_IDLE;
      S_CMP:   state_nxt = S_APPLY;
      S_APPLY: state_nxt = accept ? S_CMP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt    = count_r;
    status_nxt   = ST_OK;
    position_nxt = '0;
    found_nxt    = '0;
    case (kind_r)
      KIND_INSERT: begin
        if (any_eq) begin
          status_nxt = ST_DUPLICATE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (any_eq) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      KIND_SEARCH: begin
        if (any_eq) begin
          position_nxt = POS_W'(hit_idx);
          found_nxt    = hit_rec;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_APPLY);
      if (state_r == S_APPLY) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r        <= kind_t'(in_kind);
      req_r.key       <= in_key;
      req_r.age       <= in_age;
      req_r.name_head <= in_name_first;
      req_r.name_tail <= in_name_rest;
    end
    if (state_r == S_APPLY) begin
      status_r   <= status_nxt;
      position_r <= position_nxt;
      found_r    <= found_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_position         = position_r;
  assign out_count            = COUNT_W'(count_r);
  assign out_found_age        = found_r.age;
  assign out_found_name_first = found_r.name_head;
  assign out_found_name_rest  = found_r.name_tail;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("record count above capacity");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(eq_vec))
    else $error("more than one cell matches the request key");

  a_strobe_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_APPLY))
    else $error("result strobe without an apply cycle");

  a_accept_starts_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CMP))
    else $error("accepted request did not enter the compare cycle");

  a_no_shift_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ins_ok || rem_ok) |-> (kind_r != KIND_CLEAR && kind_r != KIND_SEARCH))
    else $error("chain shift on a request that must leave it unchanged");
`endif

endmodule
